[rtl/tcld_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the three-channel linear derating block.
// No dependencies; imported by tcld_chan and three_channel_linear_derate.
package tcld_pkg;

    // Fixed field widths
    localparam int CUR_W      = 17;
    localparam int TEMP_W     = 12;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE      = 3'd0,
        REG_FLOOR       = 3'd1,
        REG_CUR_START   = 3'd2,
        REG_CUR_END     = 3'd3,
        REG_MTEMP_START = 3'd4,
        REG_MTEMP_END   = 3'd5,
        REG_ETEMP_START = 3'd6,
        REG_ETEMP_END   = 3'd7
    } t_reg_idx;

    // How a channel factor is formed once the quotient is known
    typedef enum logic [1:0] {
        MODE_ONE   = 2'd0,
        MODE_FLOOR = 2'd1,
        MODE_RAMP  = 2'd2
    } t_mode;

endpackage

[rtl/three_channel_linear_derate.sv]
`timescale 1ns / 1ps
// Top level of the three-channel linear derating block: configuration
// registers, pipeline flow control, minimum and enable. Uses tcld_pkg, tcld_chan.

// Takes one telemetry sample per clock while o_stall is low and returns one
// result per sample, in order. Each sample is classified, multiplied, divided
// by the pipelined restoring divider of each channel one quotient bit at a
// time, turned into a channel factor, and reduced to the minimum in the output
// register. A stalled output holds the result while empty stages further up
// keep filling, and o_stall rises only once every stage holds a sample.
// Configuration writes are always ready and take effect at once; write them
// while no sample is in flight. floor_factor above 1.0 is clamped to 1.0.
module three_channel_linear_derate import tcld_pkg::*; #(
    parameter int FACTOR_FRAC_BITS = 15
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Sample channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [CUR_W-1:0]             i_motor_current_ma,
    input  logic                         i_current_ok,
    input  logic signed [TEMP_W-1:0]     i_motor_temp_dc,
    input  logic                         i_motor_temp_ok,
    input  logic signed [TEMP_W-1:0]     i_esc_temp_dc,
    input  logic                         i_esc_temp_ok,
    // Result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [OUT_W-1:0]             o_current_factor,
    output logic [OUT_W-1:0]             o_motor_temp_factor,
    output logic [OUT_W-1:0]             o_esc_temp_factor,
    output logic [OUT_W-1:0]             o_computed_factor,
    output logic [OUT_W-1:0]             o_effective_factor,
    // Configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int FW   = FACTOR_FRAC_BITS + 1;
    localparam int NSTG = FW + 4;
    localparam int CW   = (FW > OUT_W) ? FW : OUT_W;
    localparam logic [FW-1:0] ONE = {1'b1, {FACTOR_FRAC_BITS{1'b0}}};
    localparam logic [OUT_W-1:0] FLOOR_RESET =
        OUT_W'(((64'd1 << FACTOR_FRAC_BITS) * 64'd2) / 64'd5);

    // Configuration registers
    logic                     r_enable;
    logic [OUT_W-1:0]         r_floor;
    logic [CUR_W-1:0]         r_cur_start;
    logic [CUR_W-1:0]         r_cur_end;
    logic signed [TEMP_W-1:0] r_mt_start;
    logic signed [TEMP_W-1:0] r_mt_end;
    logic signed [TEMP_W-1:0] r_et_start;
    logic signed [TEMP_W-1:0] r_et_end;

    // Pipeline control
    logic [NSTG-1:0]          r_vld;
    logic [NSTG-1:0]          adv;

    logic [CW-1:0]            floor_ext;
    logic [FW-1:0]            floor_sat;
    logic [FW-1:0]            one_minus;
    logic [FW-1:0]            f_cur;
    logic [FW-1:0]            f_mt;
    logic [FW-1:0]            f_et;
    logic [FW-1:0]            f_min;

    logic [OUT_W-1:0]         r_cur_f;
    logic [OUT_W-1:0]         r_mt_f;
    logic [OUT_W-1:0]         r_et_f;
    logic [OUT_W-1:0]         r_comp_f;
    logic [OUT_W-1:0]         r_eff_f;

    // Accept register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_floor     <= FLOOR_RESET;
            r_cur_start <= CUR_W'(750);
            r_cur_end   <= CUR_W'(1250);
            r_mt_start  <= TEMP_W'(550);
            r_mt_end    <= TEMP_W'(680);
            r_et_start  <= TEMP_W'(600);
            r_et_end    <= TEMP_W'(780);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ENABLE:      r_enable    <= i_cfg_data[0];
                REG_FLOOR:       r_floor     <= i_cfg_data[OUT_W-1:0];
                REG_CUR_START:   r_cur_start <= i_cfg_data[CUR_W-1:0];
                REG_CUR_END:     r_cur_end   <= i_cfg_data[CUR_W-1:0];
                REG_MTEMP_START: r_mt_start  <= i_cfg_data[TEMP_W-1:0];
                REG_MTEMP_END:   r_mt_end    <= i_cfg_data[TEMP_W-1:0];
                REG_ETEMP_START: r_et_start  <= i_cfg_data[TEMP_W-1:0];
                REG_ETEMP_END:   r_et_end    <= i_cfg_data[TEMP_W-1:0];
                default:         r_enable    <= r_enable;
            endcase
        end
    end

    // Clamp the floor to 1.0 and form the factor span
    assign floor_ext = CW'(r_floor);
    assign floor_sat = (floor_ext > CW'(ONE)) ? ONE : FW'(floor_ext);
    assign one_minus = ONE - floor_sat;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Channel datapaths
    tcld_chan #(
        .FRAC_BITS (FACTOR_FRAC_BITS),
        .DW        (CUR_W)
    ) u_cur (
        .i_clk       (i_clk),
        .i_adv       (adv[NSTG-2:0]),
        .i_ok        (i_current_ok),
        .i_value     (signed'({1'b0, i_motor_current_ma})),
        .i_start     (signed'({1'b0, r_cur_start})),
        .i_end       (signed'({1'b0, r_cur_end})),
        .i_floor     (floor_sat),
        .i_one_minus (one_minus),
        .o_factor    (f_cur)
    );

    tcld_chan #(
        .FRAC_BITS (FACTOR_FRAC_BITS),
        .DW        (TEMP_W)
    ) u_mtemp (
        .i_clk       (i_clk),
        .i_adv       (adv[NSTG-2:0]),
        .i_ok        (i_motor_temp_ok),
        .i_value     ({i_motor_temp_dc[TEMP_W-1], i_motor_temp_dc}),
        .i_start     ({r_mt_start[TEMP_W-1], r_mt_start}),
        .i_end       ({r_mt_end[TEMP_W-1], r_mt_end}),
        .i_floor     (floor_sat),
        .i_one_minus (one_minus),
        .o_factor    (f_mt)
    );

    tcld_chan #(
        .FRAC_BITS (FACTOR_FRAC_BITS),
        .DW        (TEMP_W)
    ) u_etemp (
        .i_clk       (i_clk),
        .i_adv       (adv[NSTG-2:0]),
        .i_ok        (i_esc_temp_ok),
        .i_value     ({i_esc_temp_dc[TEMP_W-1], i_esc_temp_dc}),
        .i_start     ({r_et_start[TEMP_W-1], r_et_start}),
        .i_end       ({r_et_end[TEMP_W-1], r_et_end}),
        .i_floor     (floor_sat),
        .i_one_minus (one_minus),
        .o_factor    (f_et)
    );

    // Take the smallest channel factor
    always_comb begin
        f_min = f_cur;
        if (f_mt < f_min) begin
            f_min = f_mt;
        end
        if (f_et < f_min) begin
            f_min = f_et;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (adv[NSTG-1]) begin
            r_cur_f  <= OUT_W'(f_cur);
            r_mt_f   <= OUT_W'(f_mt);
            r_et_f   <= OUT_W'(f_et);
            r_comp_f <= OUT_W'(f_min);
            r_eff_f  <= r_enable ? OUT_W'(f_min) : OUT_W'(ONE);
        end
    end

    assign o_valid             = r_vld[NSTG-1];
    assign o_current_factor    = r_cur_f;
    assign o_motor_temp_factor = r_mt_f;
    assign o_esc_temp_factor   = r_et_f;
    assign o_computed_factor   = r_comp_f;
    assign o_effective_factor  = r_eff_f;

    // Back-pressure reaches the input only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled while a pipeline stage is empty");

    // The computed factor is one of the channel factors
    a_min_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_computed_factor == o_current_factor
                     || o_computed_factor == o_motor_temp_factor
                     || o_computed_factor == o_esc_temp_factor))
        else $error("computed factor matches no channel factor");

    // A held result is not overwritten by the stage behind it
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_comp_f) && $stable(r_eff_f)))
        else $error("stalled result changed");

    // With derating disabled the effective factor is unity
    a_disabled_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv[NSTG-1] && r_vld[NSTG-2] && !r_enable) |=> (r_eff_f == OUT_W'(ONE)))
        else $error("effective factor not unity while disabled");

endmodule

[rtl/tcld_chan.sv]
`timescale 1ns / 1ps
// One derating channel: classify, scale, restoring divide (one quotient bit
// per stage) and factor select. Depends on tcld_pkg; stage enables from the top.
module tcld_chan import tcld_pkg::*; #(
    parameter int FRAC_BITS = 15,
    parameter int DW        = 17
) (
    input  logic                      i_clk,
    input  logic [FRAC_BITS+3:0]      i_adv,
    input  logic                      i_ok,
    input  logic signed [DW:0]        i_value,
    input  logic signed [DW:0]        i_start,
    input  logic signed [DW:0]        i_end,
    input  logic [FRAC_BITS:0]        i_floor,
    input  logic [FRAC_BITS:0]        i_one_minus,
    output logic [FRAC_BITS:0]        o_factor
);

    localparam int FW = FRAC_BITS + 1;
    localparam int QW = FW;
    localparam int NW = DW + FW;
    localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [DW-1:0] r_d;
    logic [DW-1:0] r_den  [QW+1];
    t_mode         r_mode [QW+2];
    logic [NW-1:0] r_rem  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [FW-1:0] r_factor;

    logic          active;
    logic          at_end;
    t_mode         n_mode;

    // Classify the sample against its thresholds
    assign active = i_ok && (i_end > i_start) && (i_value > i_start);
    assign at_end = (i_value >= i_end);

    always_comb begin
        priority if (!active) begin
            n_mode = MODE_ONE;
        end else if (at_end) begin
            n_mode = MODE_FLOOR;
        end else begin
            n_mode = MODE_RAMP;
        end
    end

    // Stage 0: offsets into the ramp
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_d       <= DW'(i_value - i_start);
            r_den[0]  <= DW'(i_end - i_start);
            r_mode[0] <= n_mode;
        end
    end

    // Stage 1: scale the offset by the factor span
    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r_rem[0]  <= NW'(r_d) * NW'(i_one_minus);
            r_den[1]  <= r_den[0];
            r_mode[1] <= r_mode[0];
        end
    end

    // Stages 2 .. QW+1: one quotient bit each, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int B = QW - 1 - k;
        logic [NW-1:0] shifted;
        logic          ge;
        logic [QW-1:0] q_prev;
        logic [QW-1:0] q_next;

        assign shifted = NW'(r_den[k+1]) << B;
        assign ge      = (r_rem[k] >= shifted);

        if (k == 0) begin : g_first
            assign q_prev = '0;
        end else begin : g_rest
            assign q_prev = r_q[k-1];
        end

        always_comb begin
            q_next    = q_prev;
            q_next[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[k+2]) begin
                r_q[k]      <= q_next;
                r_mode[k+2] <= r_mode[k+1];
            end
        end

        // Carry remainder and divisor only where a later bit needs them
        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv[k+2]) begin
                    r_rem[k+1] <= ge ? (r_rem[k] - shifted) : r_rem[k];
                    r_den[k+2] <= r_den[k+1];
                end
            end
        end
    end

    // Stage QW+2: select the channel factor
    always_ff @(posedge i_clk) begin
        if (i_adv[QW+2]) begin
            unique case (r_mode[QW+1])
                MODE_ONE:   r_factor <= ONE;
                MODE_FLOOR: r_factor <= i_floor;
                MODE_RAMP:  r_factor <= ONE - r_q[QW-1];
                default:    r_factor <= ONE;
            endcase
        end
    end

    assign o_factor = r_factor;

endmodule

[bench/three_channel_linear_derate_chk.sv]
`timescale 1ns / 1ps
// Scoreboard for three_channel_linear_derate: mirrors the register file, predicts
// the five factors of every accepted sample and checks each result beat in order.
// Depends on tcld_pkg; instantiated beside the block by three_channel_linear_derate_tb.
module three_channel_linear_derate_chk import tcld_pkg::*; #(
    parameter int FRAC_BITS = 15
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     o_stall,
    input  logic [CUR_W-1:0]         i_motor_current_ma,
    input  logic                     i_current_ok,
    input  logic signed [TEMP_W-1:0] i_motor_temp_dc,
    input  logic                     i_motor_temp_ok,
    input  logic signed [TEMP_W-1:0] i_esc_temp_dc,
    input  logic                     i_esc_temp_ok,
    input  logic                     o_valid,
    input  logic                     i_stall,
    input  logic [OUT_W-1:0]         o_current_factor,
    input  logic [OUT_W-1:0]         o_motor_temp_factor,
    input  logic [OUT_W-1:0]         o_esc_temp_factor,
    input  logic [OUT_W-1:0]         o_computed_factor,
    input  logic [OUT_W-1:0]         o_effective_factor,
    input  logic                     i_cfg_valid,
    input  logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam longint UNITY = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic [OUT_W-1:0] cur;
        logic [OUT_W-1:0] mot;
        logic [OUT_W-1:0] esc;
        logic [OUT_W-1:0] comp;
        logic [OUT_W-1:0] eff;
    } t_factor_set;

    // Mirrored register file
    logic                     enable_q;
    logic [OUT_W-1:0]         floor_q;
    logic [CUR_W-1:0]         cur_start_q;
    logic [CUR_W-1:0]         cur_end_q;
    logic signed [TEMP_W-1:0] mt_start_q;
    logic signed [TEMP_W-1:0] mt_end_q;
    logic signed [TEMP_W-1:0] et_start_q;
    logic signed [TEMP_W-1:0] et_end_q;

    t_factor_set expected_factors[$];
    int          fail_tally = 0;
    int          pending_q = 0;

    assign o_fail_count = fail_tally;
    assign o_pending    = pending_q;

    // Linear fall from unity at start to the floor at end, quotient truncated
    function automatic longint ramp_factor(bit ok, longint v, longint s, longint e,
                                           longint flr);
        if (!ok || e <= s || v <= s)
            return UNITY;
        if (v >= e)
            return flr;
        return UNITY - ((v - s) * (UNITY - flr)) / (e - s);
    endfunction

    function automatic t_factor_set derate_sample(
        logic [CUR_W-1:0] cur, logic cur_ok,
        logic signed [TEMP_W-1:0] mt, logic mt_ok,
        logic signed [TEMP_W-1:0] et, logic et_ok);
        longint      flr, fc, fm, fe, comp, eff;
        t_factor_set f;
        // Saturate a floor above unity
        flr = longint'(floor_q);
        if (flr > UNITY)
            flr = UNITY;
        fc = ramp_factor(cur_ok, longint'(cur), longint'(cur_start_q),
                         longint'(cur_end_q), flr);
        fm = ramp_factor(mt_ok, longint'(mt), longint'(mt_start_q),
                         longint'(mt_end_q), flr);
        fe = ramp_factor(et_ok, longint'(et), longint'(et_start_q),
                         longint'(et_end_q), flr);
        comp = fc;
        if (fm < comp)
            comp = fm;
        if (fe < comp)
            comp = fe;
        eff = enable_q ? comp : UNITY;
        f.cur  = fc[OUT_W-1:0];
        f.mot  = fm[OUT_W-1:0];
        f.esc  = fe[OUT_W-1:0];
        f.comp = comp[OUT_W-1:0];
        f.eff  = eff[OUT_W-1:0];
        return f;
    endfunction

    task automatic check_field(string label, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            fail_tally++;
        end
    endtask

    // Track register writes, retire result beats, queue predictions
    always @(posedge i_clk) begin
        t_factor_set want;
        if (!i_rst_n) begin
            enable_q    = 1'b0;
            floor_q     = OUT_W'((UNITY * 2) / 5);
            cur_start_q = CUR_W'(750);
            cur_end_q   = CUR_W'(1250);
            mt_start_q  = TEMP_W'(550);
            mt_end_q    = TEMP_W'(680);
            et_start_q  = TEMP_W'(600);
            et_end_q    = TEMP_W'(780);
            expected_factors.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_ENABLE:      enable_q    = i_cfg_data[0];
                    REG_FLOOR:       floor_q     = i_cfg_data[OUT_W-1:0];
                    REG_CUR_START:   cur_start_q = i_cfg_data[CUR_W-1:0];
                    REG_CUR_END:     cur_end_q   = i_cfg_data[CUR_W-1:0];
                    REG_MTEMP_START: mt_start_q  = i_cfg_data[TEMP_W-1:0];
                    REG_MTEMP_END:   mt_end_q    = i_cfg_data[TEMP_W-1:0];
                    REG_ETEMP_START: et_start_q  = i_cfg_data[TEMP_W-1:0];
                    REG_ETEMP_END:   et_end_q    = i_cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (expected_factors.size() == 0) begin
                    $display("%0t: result beat with nothing expected: expected none, actual %0d",
                             $time, o_effective_factor);
                    fail_tally++;
                end else begin
                    want = expected_factors.pop_front();
                    check_field("current_factor", want.cur, o_current_factor);
                    check_field("motor_temp_factor", want.mot, o_motor_temp_factor);
                    check_field("esc_temp_factor", want.esc, o_esc_temp_factor);
                    check_field("computed_factor", want.comp, o_computed_factor);
                    check_field("effective_factor", want.eff, o_effective_factor);
                end
            end
            if (i_valid && !o_stall)
                expected_factors.push_back(derate_sample(
                    i_motor_current_ma, i_current_ok, i_motor_temp_dc, i_motor_temp_ok,
                    i_esc_temp_dc, i_esc_temp_ok));
        end
        pending_q <= expected_factors.size();
    end

endmodule

[bench/three_channel_linear_derate_tb.sv]
`timescale 1ns / 1ps
// Top of the derating testbench: clock, reset, register writes, sample and stall
// stimulus, and the verdict. Depends on tcld_pkg, three_channel_linear_derate_chk.
module three_channel_linear_derate_tb;
    import tcld_pkg::*;

    localparam int FRAC_BITS   = 15;
    localparam int LATENCY     = FRAC_BITS + 5;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 175;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [CUR_W-1:0]         i_motor_current_ma;
    logic                     i_current_ok;
    logic signed [TEMP_W-1:0] i_motor_temp_dc;
    logic                     i_motor_temp_ok;
    logic signed [TEMP_W-1:0] i_esc_temp_dc;
    logic                     i_esc_temp_ok;
    logic                     o_valid;
    logic                     i_stall;
    logic [OUT_W-1:0]         o_current_factor;
    logic [OUT_W-1:0]         o_motor_temp_factor;
    logic [OUT_W-1:0]         o_esc_temp_factor;
    logic [OUT_W-1:0]         o_computed_factor;
    logic [OUT_W-1:0]         o_effective_factor;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    int fail_count;
    int pending;
    bit quiet_tail;
    // Current thresholds, used to aim samples at the ramps
    int cur_lo, cur_hi, mt_lo, mt_hi, et_lo, et_hi;

    three_channel_linear_derate #(.FACTOR_FRAC_BITS(FRAC_BITS)) DUT (.*);

    three_channel_linear_derate_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: stall in random bursts, with clear stretches that are sometimes long
    initial begin
        int run;
        i_stall <= 1'b0;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (run > 0) begin
                run--;
            end else if (quiet_tail || i_stall) begin
                i_stall <= 1'b0;
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(0, 30);
            end else begin
                i_stall <= 1'b1;
                run = $urandom_range(0, 18);
            end
        end
    end

    // Hold a register beat until taken; valid stays high for the next write
    task automatic write_reg(t_reg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(bit en, int flr, int cs, int ce, int ms, int me,
                              int es, int ee);
        write_reg(REG_ENABLE, en);
        write_reg(REG_FLOOR, flr);
        write_reg(REG_CUR_START, cs);
        write_reg(REG_CUR_END, ce);
        write_reg(REG_MTEMP_START, ms);
        write_reg(REG_MTEMP_END, me);
        write_reg(REG_ETEMP_START, es);
        write_reg(REG_ETEMP_END, ee);
        i_cfg_valid <= 1'b0;
        cur_lo = cs;
        cur_hi = ce;
        mt_lo  = ms;
        mt_hi  = me;
        et_lo  = es;
        et_hi  = ee;
    endtask

    // Hold a sample beat until taken; valid stays high for the next sample
    task automatic send_sample(int cur, bit cok, int mt, bit mok, int et, bit eok);
        i_valid            <= 1'b1;
        i_motor_current_ma <= cur[CUR_W-1:0];
        i_current_ok       <= cok;
        i_motor_temp_dc    <= mt[TEMP_W-1:0];
        i_motor_temp_ok    <= mok;
        i_esc_temp_dc      <= et[TEMP_W-1:0];
        i_esc_temp_ok      <= eok;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic pause_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Pick a value at, near or between the thresholds, or any bit pattern
    function automatic int aim_value(int lo, int hi);
        int a, b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 9))
            0, 1:    return int'($urandom);
            2:       return lo;
            3:       return hi;
            4:       return lo + 1;
            5:       return hi - 1;
            default: return a - 2 + int'($urandom_range(0, b - a + 4));
        endcase
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // End threshold: equal, inverted, narrow or wide relative to the start
    function automatic int end_after(int s, int lo, int hi);
        case ($urandom_range(0, 7))
            0:       return s;
            1:       return clamp(s - int'($urandom_range(1, 50)), lo, hi);
            2:       return clamp(s + 1, lo, hi);
            3:       return clamp(s + int'($urandom_range(2, 30)), lo, hi);
            default: return clamp(s + int'($urandom_range(1, 4000)), lo, hi);
        endcase
    endfunction

    task automatic random_config();
        int flr, cs, ms, es;
        case ($urandom_range(0, 6))
            0:       flr = 0;
            1:       flr = 3277;
            2:       flr = 32768;
            3:       flr = 32767;
            4:       flr = 65535;
            5:       flr = $urandom_range(0, 65535);
            default: flr = $urandom_range(3277, 32768);
        endcase
        cs = $urandom_range(0, 100000);
        ms = int'($urandom_range(0, 2400)) - 400;
        es = int'($urandom_range(0, 2400)) - 400;
        set_config($urandom_range(0, 1), flr, cs, end_after(cs, 0, 131071),
                   ms, end_after(ms, -2048, 2047), es, end_after(es, -2048, 2047));
    endtask

    initial begin
        int n;
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_motor_current_ma <= '0;
        i_current_ok       <= 1'b0;
        i_motor_temp_dc    <= '0;
        i_motor_temp_ok    <= 1'b0;
        i_esc_temp_dc      <= '0;
        i_esc_temp_ok      <= 1'b0;
        i_cfg_valid        <= 1'b0;
        i_cfg_index        <= REG_ENABLE;
        i_cfg_data         <= '0;
        quiet_tail = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: derating disabled, so effective stays at unity
        send_sample(1000, 1, 615, 1, 690, 1);
        send_sample(1300, 1, 700, 1, 800, 1);
        send_sample(0, 0, 0, 0, 0, 0);
        drain();

        // Default windows, derating enabled: walk each ramp edge to edge
        set_config(1, 13107, 750, 1250, 550, 680, 600, 780);
        send_sample(0, 1, 0, 1, 0, 1);
        send_sample(750, 1, 550, 1, 600, 1);
        send_sample(751, 1, 551, 1, 601, 1);
        send_sample(1000, 1, 615, 1, 690, 1);
        send_sample(1249, 1, 679, 1, 779, 1);
        send_sample(1250, 1, 680, 1, 780, 1);
        send_sample(100000, 1, 2000, 1, 2000, 1);
        send_sample(131071, 1, 2047, 1, 2047, 1);
        send_sample(131071, 0, 2047, 0, 2047, 0);
        send_sample(0, 1, -2048, 1, -400, 1);
        send_sample(1100, 0, 650, 1, 700, 0);
        send_sample(900, 1, 2000, 0, 750, 1);
        drain();

        // Floor above unity, equal and inverted windows, negative start
        set_config(1, 65535, 5000, 5000, 100, -100, -400, 2000);
        send_sample(5001, 1, 0, 1, -400, 1);
        send_sample(5000, 1, 2047, 1, 800, 1);
        send_sample(100000, 1, -2048, 1, 1999, 1);
        drain();

        // Zero floor over the widest windows
        set_config(1, 0, 0, 100000, -400, 2000, -2048, 2047);
        send_sample(50000, 1, 800, 1, 0, 1);
        send_sample(99999, 1, 1999, 1, 2046, 1);
        send_sample(1, 1, -399, 1, -2047, 1);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       set_config(1, 3277, 0, 100000, -400, 2000, -400, 2000);
                1:       set_config(0, 32768, 100000, 0, 2000, -400, 2000, -400);
                2:       set_config(1, 32767, 0, 131071, -2048, 2047, -2048, 2047);
                default: random_config();
            endcase
            quiet_tail = (p == RAND_PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    pause_sender($urandom_range(1, 19));
                send_sample(aim_value(cur_lo, cur_hi), $urandom_range(0, 7) != 0,
                            aim_value(mt_lo, mt_hi), $urandom_range(0, 7) != 0,
                            aim_value(et_lo, et_hi), $urandom_range(0, 7) != 0);
            end
            drain();
        end

        // Let any stray beat surface before the verdict
        repeat (4 * LATENCY) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
